// ----- sv/dma_drm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dma_drm_pkg;

   // Ring size limits, as log2 of the number of slots.
   localparam int RING_LOG_MIN = 7;
   localparam int RING_LOG_MAX = 13;

   localparam int CSR_W     = 4;
   localparam int MODE_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int JOB_W     = 16;
   localparam int RETIRED_W = 13;
   localparam int ADDR_W    = 64;
   localparam int LEN_W     = 32;
   localparam int COUNT_W   = 64;

   localparam logic [MODE_W-1:0] MODE_COPY     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DOORBELL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POLL     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_WORK = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] src_addr;
      logic [ADDR_W-1:0] dst_addr;
      logic [LEN_W-1:0]  byte_length;
      logic              submit_now;
      logic [JOB_W-1:0]  max_completions;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [JOB_W-1:0]     job_index;
      logic [RETIRED_W-1:0] retired_count;
      logic [JOB_W-1:0]     last_index;
      logic                 exec_valid;
      logic [ADDR_W-1:0]    exec_src;
      logic [ADDR_W-1:0]    exec_dst;
      logic [LEN_W-1:0]     exec_len;
      logic [COUNT_W-1:0]   submitted_total;
      logic [COUNT_W-1:0]   completed_total;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      logic [LEN_W-1:0]  len;
      logic [JOB_W-1:0]  job;
   } desc_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic needs_read;
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/dma_descriptor_ring_manager.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Descriptor ring manager for a memory-to-memory copy channel. One circular
// descriptor store holds completed, running, pending and free slots between
// four pointers; each request beat (copy, doorbell, poll, engine tick, stats
// clear) yields exactly one response beat. Copy, doorbell, stats clear and
// unused modes, and a poll or tick with nothing to do, produce their response
// in the cycle after the request beat is taken; a poll that retires jobs and a
// tick that finds work go through the store's single registered read port
// and then the response register. One request is handled at a time, and the
// next is taken once the response register is empty or being drained. A write
// on the csr port sets log2 of the ring size (clamped to 7 up to the smaller
// of 13 and floor(log2(MAX_DESCRIPTORS))) and empties the ring; it must only
// be issued while the block is idle. The store needs no clearing after reset.
module dma_descriptor_ring_manager #(
   parameter int MAX_DESCRIPTORS = 8192
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dma_drm_pkg::req_type          req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dma_drm_pkg::rsp_type               rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [dma_drm_pkg::CSR_W-1:0] csr_wdata
);

   dma_drm_pkg::cmd_type  cmd;
   dma_drm_pkg::stat_type stat;

   dma_drm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dma_drm_dp #(
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sv/dma_drm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dma_drm_ram #(
   parameter int WIDTH = 176,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/dma_drm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dma_drm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire dma_drm_pkg::stat_type stat,
   output dma_drm_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type st_ff, st_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      finish;

   // A new beat is taken in the idle state once the result register is empty or being emptied.
   assign req_ready = (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign finish    = (st_ff == ST_FETCH);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept && stat.needs_read) begin
               st_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((accept && !stat.needs_read) || finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.accept = accept;
   assign cmd.finish = finish;

endmodule

`default_nettype wire

// ----- sv/dma_drm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dma_drm_dp #(
   parameter int MAX_DESCRIPTORS = 8192
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [dma_drm_pkg::CSR_W-1:0]         csr_wdata,
   input  wire dma_drm_pkg::req_type                  req_data,
   input  wire dma_drm_pkg::cmd_type                  cmd,
   output dma_drm_pkg::stat_type                      stat,
   output dma_drm_pkg::rsp_type                       rsp_data
);

   localparam int FLOOR_LOG = $clog2(MAX_DESCRIPTORS + 1) - 1;
   localparam int MAX_LOG   = (FLOOR_LOG > dma_drm_pkg::RING_LOG_MAX) ?
                              dma_drm_pkg::RING_LOG_MAX : FLOOR_LOG;
   localparam int PTR_W     = MAX_LOG;
   localparam int RAM_DEPTH = 1 << MAX_LOG;
   localparam int DESC_W    = $bits(dma_drm_pkg::desc_type);

   logic [PTR_W-1:0] mask_ff,  mask_in;
   logic [PTR_W-1:0] alloc_ff, alloc_in;
   logic [PTR_W-1:0] rel_ff,   rel_in;
   logic [PTR_W-1:0] exe_ff,   exe_in;
   logic [PTR_W-1:0] ret_ff,   ret_in;
   logic [dma_drm_pkg::JOB_W-1:0]   job_ff, job_in;
   logic [dma_drm_pkg::COUNT_W-1:0] sub_ff, sub_in;
   logic [dma_drm_pkg::COUNT_W-1:0] cmp_ff, cmp_in;
   dma_drm_pkg::rsp_type rsp_ff, rsp_in;
   logic fetch_tick_ff, fetch_tick_in;

   logic [dma_drm_pkg::CSR_W-1:0] lg_clamp;
   logic [PTR_W:0]   one_shift;
   logic [PTR_W-1:0] mask_cfg;
   logic [PTR_W-1:0] used;
   logic [PTR_W-1:0] alloc_next;
   logic [PTR_W-1:0] done;
   logic [PTR_W-1:0] n_retire;
   logic [PTR_W-1:0] last_addr;
   logic             ring_full;
   logic             tick_work;

   logic                  ram_we;
   logic                  ram_re;
   logic [PTR_W-1:0]      ram_raddr;
   dma_drm_pkg::desc_type wr_desc;
   dma_drm_pkg::desc_type rd_desc;
   logic [DESC_W-1:0]     ram_rdata;

   // Mask for a newly written ring size, clamped between the minimum ring size and what the store can hold.
   always_comb begin
      if (csr_wdata < dma_drm_pkg::CSR_W'(dma_drm_pkg::RING_LOG_MIN)) begin
         lg_clamp = dma_drm_pkg::CSR_W'(dma_drm_pkg::RING_LOG_MIN);
      end else if (csr_wdata > dma_drm_pkg::CSR_W'(MAX_LOG)) begin
         lg_clamp = dma_drm_pkg::CSR_W'(MAX_LOG);
      end else begin
         lg_clamp = csr_wdata;
      end
   end

   assign one_shift = {{PTR_W{1'b0}}, 1'b1} << lg_clamp;
   assign mask_cfg  = PTR_W'(one_shift - 1'b1);

   assign used       = (alloc_ff - ret_ff) & mask_ff;
   assign ring_full  = (used >= mask_ff);
   assign alloc_next = (alloc_ff + 1'b1) & mask_ff;
   assign done       = (exe_ff - ret_ff) & mask_ff;
   assign n_retire   = (req_data.max_completions < dma_drm_pkg::JOB_W'(done)) ?
                       PTR_W'(req_data.max_completions) : done;
   assign last_addr  = (ret_ff + n_retire - 1'b1) & mask_ff;
   assign tick_work  = (exe_ff != rel_ff);

   assign stat.needs_read = ((req_data.mode == dma_drm_pkg::MODE_POLL) && (n_retire != '0)) ||
                            ((req_data.mode == dma_drm_pkg::MODE_TICK) && tick_work);

   assign wr_desc.src = req_data.src_addr;
   assign wr_desc.dst = req_data.dst_addr;
   assign wr_desc.len = req_data.byte_length;
   assign wr_desc.job = job_ff;
   assign rd_desc     = ram_rdata;

   always_comb begin
      mask_in       = mask_ff;
      alloc_in      = alloc_ff;
      rel_in        = rel_ff;
      exe_in        = exe_ff;
      ret_in        = ret_ff;
      job_in        = job_ff;
      sub_in        = sub_ff;
      cmp_in        = cmp_ff;
      rsp_in        = rsp_ff;
      fetch_tick_in = fetch_tick_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = exe_ff;

      if (csr_we) begin
         // A new ring size empties the ring; job index and totals survive.
         mask_in  = mask_cfg;
         alloc_in = '0;
         rel_in   = '0;
         exe_in   = '0;
         ret_in   = '0;
      end else if (cmd.accept) begin
         rsp_in = '0;
         unique case (req_data.mode)
            dma_drm_pkg::MODE_COPY: begin
               if (ring_full) begin
                  rsp_in.status = dma_drm_pkg::STATUS_FULL;
               end else begin
                  ram_we           = 1'b1;
                  rsp_in.job_index = job_ff;
                  job_in           = job_ff + 1'b1;
                  alloc_in         = alloc_next;
                  if (req_data.submit_now) begin
                     rel_in = alloc_next;
                  end
                  sub_in = sub_ff + 1'b1;
               end
            end
            dma_drm_pkg::MODE_DOORBELL: begin
               rel_in = alloc_ff;
            end
            dma_drm_pkg::MODE_POLL: begin
               rsp_in.retired_count = dma_drm_pkg::RETIRED_W'(n_retire);
               if (n_retire != '0) begin
                  ram_re        = 1'b1;
                  ram_raddr     = last_addr;
                  fetch_tick_in = 1'b0;
                  ret_in        = (ret_ff + n_retire) & mask_ff;
               end
            end
            dma_drm_pkg::MODE_TICK: begin
               if (!tick_work) begin
                  rsp_in.status = dma_drm_pkg::STATUS_NO_WORK;
               end else begin
                  ram_re        = 1'b1;
                  ram_raddr     = exe_ff;
                  fetch_tick_in = 1'b1;
                  exe_in        = (exe_ff + 1'b1) & mask_ff;
                  cmp_in        = cmp_ff + 1'b1;
               end
            end
            dma_drm_pkg::MODE_CLEAR: begin
               sub_in = '0;
               cmp_in = '0;
            end
            default: begin
            end
         endcase
         rsp_in.submitted_total = sub_in;
         rsp_in.completed_total = cmp_in;
      end

      // The descriptor read has landed: fill in the fields that come from it.
      if (cmd.finish) begin
         if (fetch_tick_ff) begin
            rsp_in.exec_valid = 1'b1;
            rsp_in.exec_src   = rd_desc.src;
            rsp_in.exec_dst   = rd_desc.dst;
            rsp_in.exec_len   = rd_desc.len;
         end else begin
            rsp_in.last_index = rd_desc.job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '1;
         alloc_ff <= '0;
         rel_ff   <= '0;
         exe_ff   <= '0;
         ret_ff   <= '0;
         job_ff   <= '0;
         sub_ff   <= '0;
         cmp_ff   <= '0;
      end else begin
         mask_ff  <= mask_in;
         alloc_ff <= alloc_in;
         rel_ff   <= rel_in;
         exe_ff   <= exe_in;
         ret_ff   <= ret_in;
         job_ff   <= job_in;
         sub_ff   <= sub_in;
         cmp_ff   <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff        <= rsp_in;
      fetch_tick_ff <= fetch_tick_in;
   end

   dma_drm_ram #(
      .WIDTH (DESC_W),
      .DEPTH (RAM_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (alloc_ff),
      .wr_data (wr_desc),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
